@@ rtl/core/mtss_pkg.sv @@
// Shared types, constants and the quarter-wave sine generator function
// for the multi-tone sine synthesizer. No dependencies.
package mtss_pkg;

  // Default build parameters
  localparam int unsigned SAMPLES_PER_BURST_DEF = 8192;
  localparam int unsigned TONES_DEF             = 4;
  localparam int unsigned PHASE_BITS_DEF        = 32;
  localparam int unsigned TABLE_INDEX_BITS_DEF  = 12;

  // Register map
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned MAX_TONES  = 4;
  localparam int unsigned STEP_W     = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_TONE_ENABLE = 3'd0;
  localparam cfg_idx_t CFG_STEP_TONE_0 = 3'd1;
  localparam cfg_idx_t CFG_STEP_TONE_1 = 3'd2;
  localparam cfg_idx_t CFG_STEP_TONE_2 = 3'd3;
  localparam cfg_idx_t CFG_STEP_TONE_3 = 3'd4;

  typedef logic [STEP_W-1:0] step_t;

  // 1800, 2400, 3000, 3600 Hz at 8 kHz
  localparam step_t STEP_RESET_0 = 32'd966367642;
  localparam step_t STEP_RESET_1 = 32'd1288490189;
  localparam step_t STEP_RESET_2 = 32'd1610612736;
  localparam step_t STEP_RESET_3 = 32'd1932735283;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MAG_W    = 15;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [MAG_W-1:0]           mag_t;

  // floor(m/3) == (m * DIV3_MUL) >> DIV3_SHIFT for every 15-bit m
  localparam logic [15:0] DIV3_MUL   = 16'd43691;
  localparam int unsigned DIV3_SHIFT = 17;

  // Q30 Taylor coefficients of sin(pi*x/2)
  localparam logic [63:0] COEF1 = 64'd1686629713;
  localparam logic [63:0] COEF3 = 64'd693598648;
  localparam logic [63:0] COEF5 = 64'd85569311;
  localparam logic [63:0] COEF7 = 64'd5026992;
  localparam logic [63:0] COEF9 = 64'd172272;

  // Only ever called with constant arguments: folds to a ROM entry.
  function automatic mag_t quarter_value_f(input int unsigned r, input int unsigned qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] v;
    x  = 64'(r) << (30 - qbits);
    x2 = (x * x) >> 30;
    p  = COEF7 - ((x2 * COEF9) >> 30);
    p  = COEF5 - ((x2 * p) >> 30);
    p  = COEF3 - ((x2 * p) >> 30);
    p  = COEF1 - ((x2 * p) >> 30);
    s  = (x * p) >> 30;
    v  = (s * 64'd32767 + 64'd536870912) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_W-1:0];
  endfunction

endpackage

@@ rtl/core/mtss_in_if.sv @@
// Tick request channel of the multi-tone sine synthesizer.
// Independent of mtss_pkg; carries the restart flag.
interface mtss_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

@@ rtl/core/mtss_out_if.sv @@
// Sample result channel of the multi-tone sine synthesizer.
// Uses sample_t from mtss_pkg.
interface mtss_out_if
  import mtss_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    silent;
  logic    last;

  modport source (output valid, output sample, output silent, output last, input ready);
  modport sink   (input valid, input sample, input silent, input last, output ready);
endinterface

@@ rtl/core/mtss_cfg_if.sv @@
// Register write channel of the multi-tone sine synthesizer.
// Uses cfg_idx_t and CFG_DATA_W from mtss_pkg.
interface mtss_cfg_if
  import mtss_pkg::*;
;
  logic                  valid;
  logic                  ready;
  cfg_idx_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/multi_tone_sine_synth_core.sv @@
// Multi-tone NCO sine synthesizer: phase accumulators, quarter-wave ROMs,
// per-tone scaling and the output sum. Uses mtss_pkg and the mtss_*_if channels.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   restart
//   out_ch   out  valid/ready   sample[15:0] signed, silent, last
//   cfg_ch   in   valid/ready   index[2:0], data[31:0]  (ready always high)
//
// One request per cycle while out_ch is ready, passing phase/address, ROM read,
// scale and sum stages. The ROM read register sets the stage split.
// Each stage holds only while the stage after it is full and stalled, so
// bubbles collapse and a request is taken while a result waits.
// Synchronous rst_n clears phases, sample index, enables, valids; resets steps.
module multi_tone_sine_synth_core
  import mtss_pkg::*;
#(
  parameter int unsigned SAMPLES_PER_BURST = SAMPLES_PER_BURST_DEF,
  parameter int unsigned TONES             = TONES_DEF,
  parameter int unsigned PHASE_BITS        = PHASE_BITS_DEF,
  parameter int unsigned TABLE_INDEX_BITS  = TABLE_INDEX_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  mtss_in_if.sink           in_ch,
  mtss_out_if.source        out_ch,
  mtss_cfg_if.sink          cfg_ch
);

  localparam int unsigned IDX_W  = (SAMPLES_PER_BURST > 1) ? $clog2(SAMPLES_PER_BURST) : 1;
  localparam int unsigned QB     = TABLE_INDEX_BITS - 2;
  localparam int unsigned QSIZE  = 1 << QB;
  localparam int unsigned ADDR_W = QB + 1;
  localparam int unsigned CNT_W  = $clog2(MAX_TONES + 1);
  localparam int unsigned SUM_W  = SAMPLE_W + 2;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES_PER_BURST - 1);

  // ---------------- configuration ----------------
  logic [MAX_TONES-1:0] tone_enable_r;
  step_t                step_r [MAX_TONES];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_enable_r <= '0;
      step_r[0]     <= STEP_RESET_0;
      step_r[1]     <= STEP_RESET_1;
      step_r[2]     <= STEP_RESET_2;
      step_r[3]     <= STEP_RESET_3;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_TONE_ENABLE: tone_enable_r <= cfg_ch.data[MAX_TONES-1:0];
        CFG_STEP_TONE_0: step_r[0]     <= cfg_ch.data[STEP_W-1:0];
        CFG_STEP_TONE_1: step_r[1]     <= cfg_ch.data[STEP_W-1:0];
        CFG_STEP_TONE_2: step_r[2]     <= cfg_ch.data[STEP_W-1:0];
        CFG_STEP_TONE_3: step_r[3]     <= cfg_ch.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage advance ----------------
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic go1, go2, go3, go_out;
  logic in_acc;

  assign go_out = !out_v_r || out_ch.ready;
  assign go3    = !s3_v_r  || go_out;
  assign go2    = !s2_v_r  || go3;
  assign go1    = !s1_v_r  || go2;
  assign in_ch.ready = go1;
  assign in_acc = in_ch.valid && go1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (go1)    s1_v_r  <= in_ch.valid;
      if (go2)    s2_v_r  <= s1_v_r;
      if (go3)    s3_v_r  <= s2_v_r;
      if (go_out) out_v_r <= s3_v_r;
    end
  end

  // ---------------- NCO state and stage 1 ----------------
  logic [IDX_W-1:0]      idx_r;
  logic [IDX_W-1:0]      idx_use;
  logic                  last_now;
  logic [PHASE_BITS-1:0] phase_r   [TONES];
  logic [PHASE_BITS-1:0] phase_use [TONES];
  logic [ADDR_W-1:0]     addr_nxt  [TONES];
  logic [TONES-1:0]      neg_nxt;
  logic [CNT_W-1:0]      cnt_nxt;

  logic [ADDR_W-1:0]     s1_addr_r [TONES];
  logic [TONES-1:0]      s1_neg_r, s1_en_r;
  logic [CNT_W-1:0]      s1_cnt_r;
  logic                  s1_last_r;

  assign idx_use  = in_ch.restart ? '0 : idx_r;
  assign last_now = (idx_use == IDX_LAST);

  always_comb begin
    cnt_nxt = '0;
    for (int i = 0; i < TONES; i++) begin
      cnt_nxt = cnt_nxt + CNT_W'(tone_enable_r[i]);
    end
  end

  for (genvar i = 0; i < TONES; i++) begin : g_addr
    logic [TABLE_INDEX_BITS-1:0] k;
    logic [QB-1:0]               r;
    assign phase_use[i] = in_ch.restart ? '0 : phase_r[i];
    assign k            = phase_use[i][PHASE_BITS-1 -: TABLE_INDEX_BITS];
    assign r            = k[QB-1:0];
    // odd quadrants run the quarter wave backwards
    assign addr_nxt[i]  = k[QB] ? (ADDR_W'(QSIZE) - {1'b0, r}) : {1'b0, r};
    assign neg_nxt[i]   = k[QB+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      for (int i = 0; i < TONES; i++) begin
        phase_r[i] <= '0;
      end
    end else if (in_acc) begin
      idx_r <= last_now ? '0 : idx_use + IDX_W'(1);
      for (int i = 0; i < TONES; i++) begin
        phase_r[i] <= last_now ? '0 : phase_use[i] + PHASE_BITS'(step_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go1) begin
      s1_addr_r <= addr_nxt;
      s1_neg_r  <= neg_nxt;
      s1_en_r   <= tone_enable_r[TONES-1:0];
      s1_cnt_r  <= cnt_nxt;
      s1_last_r <= last_now;
    end
  end

  // ---------------- stage 2: quarter-wave ROM read ----------------
  mag_t             s2_mag_r [TONES];
  logic [TONES-1:0] s2_neg_r, s2_en_r;
  logic [CNT_W-1:0] s2_cnt_r;
  logic             s2_last_r;

  for (genvar i = 0; i < TONES; i++) begin : g_rom
    mag_t qtab [QSIZE+1];
    for (genvar k = 0; k <= QSIZE; k++) begin : g_ent
      assign qtab[k] = quarter_value_f(k, QB);
    end
    always_ff @(posedge clk) begin
      if (go2) begin
        s2_mag_r[i] <= qtab[s1_addr_r[i]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go2) begin
      s2_neg_r  <= s1_neg_r;
      s2_en_r   <= s1_en_r;
      s2_cnt_r  <= s1_cnt_r;
      s2_last_r <= s1_last_r;
    end
  end

  // ---------------- stage 3: divide by tone count ----------------
  // Magnitude divided then negated: truncation toward zero.
  sample_t          quo_nxt [TONES];
  sample_t          s3_q_r  [TONES];
  logic             s3_silent_r, s3_last_r;

  for (genvar i = 0; i < TONES; i++) begin : g_div
    logic [MAG_W+16:0] prod3;
    mag_t              q;
    assign prod3 = (MAG_W+17)'(s2_mag_r[i]) * (MAG_W+17)'(DIV3_MUL);
    always_comb begin
      unique case (s2_cnt_r)
        CNT_W'(1): q = s2_mag_r[i];
        CNT_W'(2): q = s2_mag_r[i] >> 1;
        CNT_W'(3): q = prod3[DIV3_SHIFT +: MAG_W];
        CNT_W'(4): q = s2_mag_r[i] >> 2;
        default:   q = '0;
      endcase
      if (!s2_en_r[i]) begin
        quo_nxt[i] = '0;
      end else if (s2_neg_r[i]) begin
        quo_nxt[i] = -sample_t'({1'b0, q});
      end else begin
        quo_nxt[i] = sample_t'({1'b0, q});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go3) begin
      s3_q_r      <= quo_nxt;
      s3_silent_r <= (s2_cnt_r == '0);
      s3_last_r   <= s2_last_r;
    end
  end

  // ---------------- output stage: sum ----------------
  logic signed [SUM_W-1:0] sum_nxt;
  sample_t                 out_sample_r;
  logic                    out_silent_r, out_last_r;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < TONES; i++) begin
      sum_nxt = sum_nxt + SUM_W'(s3_q_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (go_out) begin
      out_sample_r <= sum_nxt[SAMPLE_W-1:0];
      out_silent_r <= s3_silent_r;
      out_last_r   <= s3_last_r;
    end
  end

  assign out_ch.valid  = out_v_r;
  assign out_ch.sample = out_sample_r;
  assign out_ch.silent = out_silent_r;
  assign out_ch.last   = out_last_r;

`ifndef SYNTHESIS
  a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_silent_r |-> out_sample_r == '0)
    else $error("silent sample is not zero");

  a_burst_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && last_now |=> idx_r == '0)
    else $error("sample index did not wrap at burst end");

  a_restart_idx: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.restart |=> idx_r == IDX_W'(SAMPLES_PER_BURST > 1))
    else $error("restart did not clear sample index");
`endif

endmodule
